### sv/a2r_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the atan2 rational approximation block.
// No dependencies; used by every module of the block.
package a2r_pkg;

  localparam int SAMPLE_BITS_DEF     = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 13;
  localparam int ANGLE_BITS          = 16;

  // pi with 60 fraction bits
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

  // per-item sideband that rides along the divider chain
  typedef struct packed {
    logic xneg;
    logic yneg;
    logic swap;   // |y| > |x|: result is +-(pi/2 - q)
    logic err;    // both coordinates zero
  } ctl_t;

  // pi rounded to nearest at f fraction bits
  function automatic logic [63:0] pi_fixed(input int f);
    logic [63:0] r;
    r = (PI_Q60 + (64'd1 << (59 - f))) >> (60 - f);
    return r;
  endfunction

  // pi/2 rounded to nearest at f fraction bits
  function automatic logic [63:0] half_pi_fixed(input int f);
    logic [63:0] r;
    r = (PI_Q60 + (64'd1 << (60 - f))) >> (61 - f);
    return r;
  endfunction

endpackage

### sv/a2r_front.sv
`timescale 1ns / 1ps
// Front pipeline: magnitudes and ordering, squares and cross product, then
// the divider's dividend and divisor. Depends on a2r_pkg.
module a2r_front #(
  parameter int SAMPLE_BITS = a2r_pkg::SAMPLE_BITS_DEF,
  parameter int W           = 2 * a2r_pkg::SAMPLE_BITS_DEF + 6
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [SAMPLE_BITS-1:0]    y_in,
  input  logic [SAMPLE_BITS-1:0]    x_in,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [W-1:0]              out_rem,
  output logic [W-1:0]              out_den,
  output a2r_pkg::ctl_t             out_ctl
);

  localparam int S = SAMPLE_BITS;

  logic v0, v1, v2;
  logic rdy0, rdy1, rdy2;

  logic [S-1:0]   ax, by;
  logic [S-1:0]   mn, mx;
  a2r_pkg::ctl_t  c0, c1, c2;
  a2r_pkg::ctl_t  c_next;

  logic [2*S-1:0] mxx, mnn, mnx;
  logic [W-1:0]   den, num;
  logic [W-1:0]   mxx_w, mnn_w, mnx_w;

  assign rdy2     = !v2 || out_ready;
  assign rdy1     = !v1 || rdy2;
  assign rdy0     = !v0 || rdy1;
  assign in_ready = rdy0;

  always_comb begin
    ax = x_in[S-1] ? S'(-x_in) : x_in;
    by = y_in[S-1] ? S'(-y_in) : y_in;
    c_next.xneg = x_in[S-1];
    c_next.yneg = y_in[S-1];
    c_next.swap = by > ax;
    c_next.err  = (x_in == '0) && (y_in == '0);
  end

  // stage 0: min / max of the magnitudes
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (rdy0) begin
      v0 <= in_valid;
    end
    if (rdy0 && in_valid) begin
      mn <= c_next.swap ? ax : by;
      mx <= c_next.swap ? by : ax;
      c0 <= c_next;
    end
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= v0;
    end
    if (rdy1 && v0) begin
      mxx <= mx * mx;
      mnn <= mn * mn;
      mnx <= mn * mx;
      c1  <= c0;
    end
  end

  // stage 2: den = 100*mx^2 + 28*mn^2, num = 100*mn*mx
  assign mxx_w = W'(mxx);
  assign mnn_w = W'(mnn);
  assign mnx_w = W'(mnx);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2 && v1) begin
      den <= (mxx_w << 6) + (mxx_w << 5) + (mxx_w << 2) + (mnn_w << 5) - (mnn_w << 2);
      num <= (mnx_w << 6) + (mnx_w << 5) + (mnx_w << 2);
      c2  <= c1;
    end
  end

  assign out_valid = v2;
  assign out_rem   = num;
  assign out_den   = den;
  assign out_ctl   = c2;

endmodule

### sv/a2r_div_cell.sv
`timescale 1ns / 1ps
// One restoring-division cell: yields one quotient bit per item and hands
// remainder, divisor, partial quotient and sideband to the next. Uses a2r_pkg.
module a2r_div_cell #(
  parameter int W = 2 * a2r_pkg::SAMPLE_BITS_DEF + 6,
  parameter int F = a2r_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [W-1:0]   in_rem,
  input  logic [W-1:0]   in_den,
  input  logic [F-1:0]   in_quo,
  input  a2r_pkg::ctl_t  in_ctl,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [W-1:0]   out_rem,
  output logic [W-1:0]   out_den,
  output logic [F-1:0]   out_quo,
  output a2r_pkg::ctl_t  out_ctl
);

  logic         valid;
  logic [W:0]   rem2;
  logic         ge;
  logic [W-1:0] rem_next;

  assign in_ready = !valid || out_ready;

  always_comb begin
    rem2     = {in_rem, 1'b0};
    ge       = rem2 >= {1'b0, in_den};
    rem_next = ge ? W'(rem2 - {1'b0, in_den}) : W'(rem2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_rem <= rem_next;
      out_den <= in_den;
      out_quo <= {in_quo[F-2:0], ge};
      out_ctl <= in_ctl;
    end
  end

  assign out_valid = valid;

endmodule

### sv/atan2_rational_approx.sv
`timescale 1ns / 1ps
// atan2 by the 0.28 rational approximation, streaming top level.
// Depends on a2r_pkg, a2r_front and a2r_div_cell.
//
// Usage:
//   Slave channel s_*: one item per handshake, s_tdata = {x_in, y_in} with
//   y_in in the low SAMPLE_BITS bits, zero-padded to whole bytes.
//   Master channel m_*: m_tdata = angle (signed, ANGLE_FRAC_BITS fraction
//   bits, 16 bits), m_tuser = domain_error (both coordinates zero).
//   Pipeline: three front stages, one divider cell per quotient bit, one
//   output register.
//   Throughput: one item per cycle while the receiver does not stall; each
//   cell of the divider chain holds one item, so the whole pipeline carries
//   up to ANGLE_FRAC_BITS + 4 items in flight.
//   Reset empties every stage; no item is in flight afterwards.
//   When the receiver stalls, the result holds on m_tdata/m_tuser and items
//   keep moving forward into empty stages; s_tready drops only once every
//   stage between input and output holds an item.
//   The block keeps no state between items.
module atan2_rational_approx #(
  parameter int SAMPLE_BITS     = a2r_pkg::SAMPLE_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = a2r_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [((2 * SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // y_in, x_in, zero pad
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [a2r_pkg::ANGLE_BITS-1:0] m_tdata,  // angle
  output logic                 m_tuser    // domain_error
);

  localparam int S    = SAMPLE_BITS;
  localparam int F    = ANGLE_FRAC_BITS;
  localparam int W    = 2 * SAMPLE_BITS + 6;
  localparam int AB   = a2r_pkg::ANGLE_BITS;
  localparam int SW   = (ANGLE_FRAC_BITS + 5 > AB + 1) ? ANGLE_FRAC_BITS + 5 : AB + 1;

  localparam logic signed [SW-1:0] PI_Q   = SW'(a2r_pkg::pi_fixed(ANGLE_FRAC_BITS));
  localparam logic signed [SW-1:0] HALF_Q = SW'(a2r_pkg::half_pi_fixed(ANGLE_FRAC_BITS));
  localparam logic signed [SW-1:0] SAT_HI = SW'((1 << (AB - 1)) - 1);
  localparam logic signed [SW-1:0] SAT_LO = -SW'(1 << (AB - 1));

  logic                 lv   [0:F];
  logic                 rdy  [0:F];
  logic [W-1:0]         lrem [0:F];
  logic [W-1:0]         lden [0:F];
  logic [F-1:0]         lquo [0:F];
  a2r_pkg::ctl_t        lctl [0:F];

  logic                 out_rdy;
  a2r_pkg::ctl_t        fc;
  logic                 neg;
  logic signed [SW-1:0] qv, qs, hs, val;
  logic [AB-1:0]        angle_next;

  a2r_front #(
    .SAMPLE_BITS (S),
    .W           (W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .y_in      (s_tdata[S-1:0]),
    .x_in      (s_tdata[2*S-1:S]),
    .out_valid (lv[0]),
    .out_ready (rdy[0]),
    .out_rem   (lrem[0]),
    .out_den   (lden[0]),
    .out_ctl   (lctl[0])
  );

  assign lquo[0] = '0;

  for (genvar k = 0; k < F; k++) begin : g_cell
    a2r_div_cell #(
      .W (W),
      .F (F)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (lv[k]),
      .in_ready  (rdy[k]),
      .in_rem    (lrem[k]),
      .in_den    (lden[k]),
      .in_quo    (lquo[k]),
      .in_ctl    (lctl[k]),
      .out_valid (lv[k+1]),
      .out_ready (rdy[k+1]),
      .out_rem   (lrem[k+1]),
      .out_den   (lden[k+1]),
      .out_quo   (lquo[k+1]),
      .out_ctl   (lctl[k+1])
    );
  end

  assign out_rdy = !m_tvalid || m_tready;
  assign rdy[F]  = out_rdy;

  // quadrant correction and saturation
  always_comb begin
    fc  = lctl[F];
    neg = fc.xneg ^ fc.yneg;
    qv  = SW'(lquo[F]);
    qs  = neg ? -qv : qv;
    hs  = neg ? -HALF_Q : HALF_Q;
    val = fc.swap ? hs - qs : qs;
    if (fc.xneg) begin
      val = val + (fc.yneg ? -PI_Q : PI_Q);
    end
    if (fc.err) begin
      val = '0;
    end
    if (val > SAT_HI) begin
      val = SAT_HI;
    end else if (val < SAT_LO) begin
      val = SAT_LO;
    end
    angle_next = val[AB-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_rdy) begin
      m_tvalid <= lv[F];
    end
    if (out_rdy && lv[F]) begin
      m_tdata <= angle_next;
      m_tuser <= fc.err;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("domain error with nonzero angle");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output stage empty");

endmodule
